// ===== rtl/rotation_to_align_vectors_top_macros.svh =====
// assertion macros for the rotation block
`ifndef ROTATION_TO_ALIGN_VECTORS_TOP_MACROS_SVH
`define ROTATION_TO_ALIGN_VECTORS_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RTAV_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// two expressions agree at every clock edge
`define RTAV_ASSERT_EQUAL(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) == (b)) \
		else $error(msg);

`endif

// ===== rtl/rtav_pkg.sv =====
`timescale 1ns / 1ps
package rtav_pkg;
	localparam int IN_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF = 14;

	localparam int Q_FRAC   = 30;
	localparam int Q30_W    = 32;
	localparam int SCALE_LO = 14;
	localparam int SCALE_HI = 15;
	localparam int SM_W     = 16;
	localparam int SQ_STEPS = 32;
	localparam int UQ_W     = 31;
	localparam int VQ_W     = 36;
	localparam int OUT_W    = 16;

	localparam int UNIT_LAT = 4 + SQ_STEPS + UQ_W + 1;
	localparam int TOP_LAT  = UNIT_LAT + 5 + VQ_W;

	typedef logic signed [Q30_W-1:0] q30_t;
	typedef logic signed [63:0]      prod_t;

	localparam q30_t ONE_Q30 = 32'sd1 <<< Q_FRAC;
	localparam q30_t EPS_Q30 = 32'sd128;

	localparam logic [1:0] ST_GENERAL  = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_OPPOSITE = 2'd2;
endpackage

// ===== rtl/rtav_unit.sv =====
`timescale 1ns / 1ps
module rtav_unit #(
	parameter int IN_WIDTH = rtav_pkg::IN_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic signed [IN_WIDTH-1:0] x,
	input  logic signed [IN_WIDTH-1:0] y,
	input  logic signed [IN_WIDTH-1:0] z,
	output logic                       out_valid,
	output rtav_pkg::q30_t             u_x,
	output rtav_pkg::q30_t             u_y,
	output rtav_pkg::q30_t             u_z
);
	import rtav_pkg::*;

	localparam int MW  = IN_WIDTH + SCALE_LO;
	localparam int RSW = $clog2(IN_WIDTH + 1);
	localparam int LSW = $clog2(SCALE_LO + 1);
	localparam logic [MW-1:0] LO_LIM = MW'(1) << SCALE_LO;
	localparam logic [MW-1:0] HI_LIM = MW'(1) << SCALE_HI;

	// split into sign and magnitude, pick the scaling shift
	logic [IN_WIDTH-1:0] raw [3];
	logic                neg_c [3];
	logic [IN_WIDTH-1:0] mag_c [3];
	logic [IN_WIDTH-1:0] m_c;
	logic [MW-1:0]       m_ext;
	logic [LSW-1:0]      ls_c;
	logic [RSW-1:0]      rs_c;

	assign raw[0] = x;
	assign raw[1] = y;
	assign raw[2] = z;

	always_comb begin
		m_c = '0;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = raw[i][IN_WIDTH-1];
			mag_c[i] = neg_c[i] ? (~raw[i] + 1'b1) : raw[i];
			if (mag_c[i] > m_c) m_c = mag_c[i];
		end
		m_ext = {{SCALE_LO{1'b0}}, m_c};
		ls_c = '0;
		for (int k = SCALE_LO; k >= 0; k--) begin
			if ((m_ext << k) >= LO_LIM) ls_c = LSW'(k);
		end
		rs_c = '0;
		for (int k = IN_WIDTH; k >= 0; k--) begin
			if ((m_ext >> k) <= HI_LIM) rs_c = RSW'(k);
		end
	end

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                neg_s1 [3];
	logic [IN_WIDTH-1:0] mag_s1 [3];
	logic                zero_s1;
	logic [LSW-1:0]      ls_s1;
	logic [RSW-1:0]      rs_s1;

	logic                neg_s2 [3];
	logic [SM_W-1:0]     sm_s2 [3];
	logic                zero_s2;
	logic                neg_s3 [3];
	logic [SM_W-1:0]     sm_s3 [3];
	logic [2*SM_W-1:0]   sq_s3 [3];
	logic                zero_s3;
	logic                neg_s4 [3];
	logic [SM_W-1:0]     sm_s4 [3];
	logic [2*SM_W-1:0]   sumsq_s4;
	logic                zero_s4;
	logic [2*SM_W+1:0]   sum_c;

	assign sum_c = {2'b0, sq_s3[0]} + {2'b0, sq_s3[1]} + {2'b0, sq_s3[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= neg_c[i];
			mag_s1[i] <= mag_c[i];
			neg_s2[i] <= neg_s1[i];
			sm_s2[i]  <= SM_W'(({{SCALE_LO{1'b0}}, mag_s1[i]} << ls_s1) >> rs_s1);
			neg_s3[i] <= neg_s2[i];
			sm_s3[i]  <= sm_s2[i];
			sq_s3[i]  <= sm_s2[i] * sm_s2[i];
			neg_s4[i] <= neg_s3[i];
			sm_s4[i]  <= sm_s3[i];
		end
		zero_s1  <= (m_c == '0);
		ls_s1    <= ls_c;
		rs_s1    <= rs_c;
		zero_s2  <= zero_s1;
		zero_s3  <= zero_s2;
		zero_s4  <= zero_s3;
		sumsq_s4 <= sum_c[2*SM_W-1:0];
	end

	// square root of sumsq * 2^32, one root bit per stage
	logic [34:0]       rt_rem_s  [0:SQ_STEPS];
	logic [31:0]       rt_root_s [0:SQ_STEPS];
	logic [31:0]       rt_x_s    [0:SQ_STEPS];
	logic [SM_W-1:0]   rt_sm_s   [0:SQ_STEPS][0:2];
	logic              rt_neg_s  [0:SQ_STEPS][0:2];
	logic              rt_zero_s [0:SQ_STEPS];
	logic              rt_v_s    [0:SQ_STEPS];

	always_comb begin
		rt_rem_s[0]  = '0;
		rt_root_s[0] = '0;
		rt_x_s[0]    = sumsq_s4;
		rt_zero_s[0] = zero_s4;
		rt_v_s[0]    = v_s4;
		for (int i = 0; i < 3; i++) begin
			rt_sm_s[0][i]  = sm_s4[i];
			rt_neg_s[0][i] = neg_s4[i];
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam int I = SQ_STEPS - 1 - j;
		logic [1:0]  pair;
		logic [34:0] t_rem;
		logic [34:0] trial;
		if (I >= SQ_STEPS / 2) begin : g_hi
			assign pair = rt_x_s[j][2*(I-SQ_STEPS/2)+1 -: 2];
		end else begin : g_lo
			assign pair = 2'b00;
		end
		assign t_rem = {rt_rem_s[j][32:0], pair};
		assign trial = {1'b0, rt_root_s[j], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[j+1] <= 1'b0;
			else         rt_v_s[j+1] <= rt_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (t_rem >= trial) begin
				rt_rem_s[j+1]  <= t_rem - trial;
				rt_root_s[j+1] <= {rt_root_s[j][30:0], 1'b1};
			end else begin
				rt_rem_s[j+1]  <= t_rem;
				rt_root_s[j+1] <= {rt_root_s[j][30:0], 1'b0};
			end
			rt_x_s[j+1]    <= rt_x_s[j];
			rt_zero_s[j+1] <= rt_zero_s[j];
			for (int i = 0; i < 3; i++) begin
				rt_sm_s[j+1][i]  <= rt_sm_s[j][i];
				rt_neg_s[j+1][i] <= rt_neg_s[j][i];
			end
		end
	end

	// magnitude * 2^46 / norm, one quotient bit per stage
	logic [31:0]     dv_rem_s  [0:UQ_W][0:2];
	logic [UQ_W-1:0] dv_q_s    [0:UQ_W][0:2];
	logic            dv_neg_s  [0:UQ_W][0:2];
	logic [31:0]     dv_den_s  [0:UQ_W];
	logic            dv_zero_s [0:UQ_W];
	logic            dv_v_s    [0:UQ_W];

	always_comb begin
		dv_den_s[0]  = rt_root_s[SQ_STEPS];
		dv_zero_s[0] = rt_zero_s[SQ_STEPS];
		dv_v_s[0]    = rt_v_s[SQ_STEPS];
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] = {1'b0, rt_sm_s[SQ_STEPS][i], 15'b0};
			dv_q_s[0][i]   = '0;
			dv_neg_s[0][i] = rt_neg_s[SQ_STEPS][i];
		end
	end

	for (genvar j = 0; j < UQ_W; j++) begin : g_udiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else         dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			logic [32:0] t;
			for (int i = 0; i < 3; i++) begin
				t = {dv_rem_s[j][i], 1'b0};
				if (t >= {1'b0, dv_den_s[j]}) begin
					dv_rem_s[j+1][i] <= 32'(t - {1'b0, dv_den_s[j]});
					dv_q_s[j+1][i]   <= {dv_q_s[j][i][UQ_W-2:0], 1'b1};
				end else begin
					dv_rem_s[j+1][i] <= t[31:0];
					dv_q_s[j+1][i]   <= {dv_q_s[j][i][UQ_W-2:0], 1'b0};
				end
				dv_neg_s[j+1][i] <= dv_neg_s[j][i];
			end
			dv_den_s[j+1]  <= dv_den_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
		end
	end

	// signed unit components, zero vector stays zero
	logic v_out_q;
	q30_t u_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else         v_out_q <= dv_v_s[UQ_W];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[UQ_W])    u_q[i] <= '0;
			else if (dv_neg_s[UQ_W][i]) u_q[i] <= -$signed({1'b0, dv_q_s[UQ_W][i]});
			else                    u_q[i] <= $signed({1'b0, dv_q_s[UQ_W][i]});
		end
	end

	assign out_valid = v_out_q;
	assign u_x = u_q[0];
	assign u_y = u_q[1];
	assign u_z = u_q[2];
endmodule

// ===== rtl/rotation_to_align_vectors_top.sv =====
// rotation matrix that turns the source direction onto the target direction
// throughput: one vector pair per cycle, fully pipelined, busy stays low
// the sqrt and the two long dividers each retire one result bit per stage
// reset clears only the valid bits; payload registers are not reset
`timescale 1ns / 1ps
`include "rotation_to_align_vectors_top_macros.svh"
module rotation_to_align_vectors_top #(
	parameter int IN_WIDTH  = rtav_pkg::IN_WIDTH_DEF,
	parameter int FRAC_BITS = rtav_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [IN_WIDTH-1:0] src_x,
	input  logic signed [IN_WIDTH-1:0] src_y,
	input  logic signed [IN_WIDTH-1:0] src_z,
	input  logic signed [IN_WIDTH-1:0] dst_x,
	input  logic signed [IN_WIDTH-1:0] dst_y,
	input  logic signed [IN_WIDTH-1:0] dst_z,
	output logic                       done,
	output logic signed [15:0]         r00,
	output logic signed [15:0]         r01,
	output logic signed [15:0]         r02,
	output logic signed [15:0]         r10,
	output logic signed [15:0]         r11,
	output logic signed [15:0]         r12,
	output logic signed [15:0]         r20,
	output logic signed [15:0]         r21,
	output logic signed [15:0]         r22,
	output logic [1:0]                 status
);
	import rtav_pkg::*;

	localparam int SH = Q_FRAC - FRAC_BITS;
	localparam logic signed [39:0] RND     = (40'sd1 << SH) >> 1;
	localparam logic signed [39:0] ONE_W   = 40'sd1 <<< Q_FRAC;
	localparam logic signed [39:0] SAT_HI  = 40'sd32767;
	localparam logic signed [39:0] SAT_LO  = -40'sd32768;

	// the receiver never stalls, so every start transfer is taken
	logic in_valid;
	assign busy     = 1'b0;
	assign in_valid = start & ~busy;

	// unit vectors, both sides run in lockstep
	logic a_valid, b_valid;
	q30_t a [3];
	q30_t b [3];

	rtav_unit #(.IN_WIDTH(IN_WIDTH)) u_src (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.x        (src_x),
		.y        (src_y),
		.z        (src_z),
		.out_valid(a_valid),
		.u_x      (a[0]),
		.u_y      (a[1]),
		.u_z      (a[2])
	);

	rtav_unit #(.IN_WIDTH(IN_WIDTH)) u_dst (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.x        (dst_x),
		.y        (dst_y),
		.z        (dst_z),
		.out_valid(b_valid),
		.u_x      (b[0]),
		.u_y      (b[1]),
		.u_z      (b[2])
	);

	// stage 1: all nine products a_i * b_j
	logic  v_s1;
	prod_t p_s1 [3][3];

	// stage 2: c and v, floored back to Q30, degenerate checks
	logic  v_s2, par_s2, opp_s2;
	q30_t  c_s2;
	q30_t  vv_s2 [3];
	prod_t dsum_c, x0_c, x1_c, x2_c;

	assign dsum_c = p_s1[0][0] + p_s1[1][1] + p_s1[2][2];
	assign x0_c   = p_s1[1][2] - p_s1[2][1];
	assign x1_c   = p_s1[2][0] - p_s1[0][2];
	assign x2_c   = p_s1[0][1] - p_s1[1][0];

	// stage 3: 1 + c and the six distinct v_i * v_j products
	// lanes: v0v0, v1v1, v2v2, v0v1, v0v2, v1v2
	logic        v_s3, par_s3, opp_s3;
	q30_t        c_s3;
	q30_t        vv_s3 [3];
	logic [31:0] den_s3;
	prod_t       pp_s3 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= a_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		q30_t c_n;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[i][j] <= a[i] * b[j];
			end
		end
		c_n      = Q30_W'(dsum_c >>> Q_FRAC);
		c_s2     <= c_n;
		par_s2   <= (c_n > (ONE_Q30 - EPS_Q30));
		opp_s2   <= (c_n < (EPS_Q30 - ONE_Q30));
		vv_s2[0] <= Q30_W'(x0_c >>> Q_FRAC);
		vv_s2[1] <= Q30_W'(x1_c >>> Q_FRAC);
		vv_s2[2] <= Q30_W'(x2_c >>> Q_FRAC);

		c_s3     <= c_s2;
		par_s3   <= par_s2;
		opp_s3   <= opp_s2;
		vv_s3    <= vv_s2;
		den_s3   <= 32'(ONE_Q30 + c_s2);
		pp_s3[0] <= vv_s2[0] * vv_s2[0];
		pp_s3[1] <= vv_s2[1] * vv_s2[1];
		pp_s3[2] <= vv_s2[2] * vv_s2[2];
		pp_s3[3] <= vv_s2[0] * vv_s2[1];
		pp_s3[4] <= vv_s2[0] * vv_s2[2];
		pp_s3[5] <= vv_s2[1] * vv_s2[2];
	end

	// stage 4 onward: v_i v_j / (1 + c), truncated toward zero on magnitudes,
	// quotients of 2^VQ_W or more are flagged and saturate at the output
	logic [31:0]     dq_rem_s [0:VQ_W][0:5];
	logic [VQ_W-1:0] dq_q_s   [0:VQ_W][0:5];
	logic [VQ_W-1:0] dq_lo_s  [0:VQ_W][0:5];
	logic            dq_neg_s [0:VQ_W][0:5];
	logic            dq_ovf_s [0:VQ_W][0:5];
	logic [31:0]     dq_den_s [0:VQ_W];
	q30_t            dq_c_s   [0:VQ_W];
	q30_t            dq_v_s   [0:VQ_W][0:2];
	logic            dq_par_s [0:VQ_W];
	logic            dq_opp_s [0:VQ_W];
	logic            dq_vld_s [0:VQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dq_vld_s[0] <= 1'b0;
		else         dq_vld_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		logic [63:0] mag;
		for (int k = 0; k < 6; k++) begin
			mag = pp_s3[k][63] ? 64'(-pp_s3[k]) : 64'(pp_s3[k]);
			dq_neg_s[0][k] <= pp_s3[k][63];
			dq_ovf_s[0][k] <= ({4'b0, mag[63:VQ_W]} >= den_s3);
			dq_rem_s[0][k] <= {4'b0, mag[63:VQ_W]};
			dq_lo_s[0][k]  <= mag[VQ_W-1:0];
			dq_q_s[0][k]   <= '0;
		end
		dq_den_s[0] <= den_s3;
		dq_c_s[0]   <= c_s3;
		dq_par_s[0] <= par_s3;
		dq_opp_s[0] <= opp_s3;
		for (int i = 0; i < 3; i++) dq_v_s[0][i] <= vv_s3[i];
	end

	for (genvar j = 0; j < VQ_W; j++) begin : g_vdiv
		localparam int B = VQ_W - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dq_vld_s[j+1] <= 1'b0;
			else         dq_vld_s[j+1] <= dq_vld_s[j];
		end

		always_ff @(posedge clk) begin
			logic [32:0] t;
			for (int k = 0; k < 6; k++) begin
				t = {dq_rem_s[j][k], dq_lo_s[j][k][B]};
				if (t >= {1'b0, dq_den_s[j]}) begin
					dq_rem_s[j+1][k] <= 32'(t - {1'b0, dq_den_s[j]});
					dq_q_s[j+1][k]   <= {dq_q_s[j][k][VQ_W-2:0], 1'b1};
				end else begin
					dq_rem_s[j+1][k] <= t[31:0];
					dq_q_s[j+1][k]   <= {dq_q_s[j][k][VQ_W-2:0], 1'b0};
				end
				dq_lo_s[j+1][k]  <= dq_lo_s[j][k];
				dq_neg_s[j+1][k] <= dq_neg_s[j][k];
				dq_ovf_s[j+1][k] <= dq_ovf_s[j][k];
			end
			dq_den_s[j+1] <= dq_den_s[j];
			dq_c_s[j+1]   <= dq_c_s[j];
			dq_par_s[j+1] <= dq_par_s[j];
			dq_opp_s[j+1] <= dq_opp_s[j];
			for (int i = 0; i < 3; i++) dq_v_s[j+1][i] <= dq_v_s[j][i];
		end
	end

	// final stage: assemble R, round half up to FRAC_BITS, saturate
	function automatic logic signed [15:0] to_out(input logic signed [39:0] xv);
		logic signed [39:0] yv;
		yv = (xv + RND) >>> SH;
		if (yv > SAT_HI)      return 16'sh7fff;
		else if (yv < SAT_LO) return 16'sh8000;
		else                  return yv[15:0];
	endfunction

	logic signed [39:0] qs [6];
	logic signed [39:0] cw, v0w, v1w, v2w;
	logic signed [39:0] ent [9];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			if (dq_ovf_s[VQ_W][k])
				qs[k] = dq_neg_s[VQ_W][k] ? -(40'sd1 <<< VQ_W) : (40'sd1 <<< VQ_W);
			else if (dq_neg_s[VQ_W][k])
				qs[k] = -$signed({4'b0, dq_q_s[VQ_W][k]});
			else
				qs[k] = $signed({4'b0, dq_q_s[VQ_W][k]});
		end
		cw  = 40'(dq_c_s[VQ_W]);
		v0w = 40'(dq_v_s[VQ_W][0]);
		v1w = 40'(dq_v_s[VQ_W][1]);
		v2w = 40'(dq_v_s[VQ_W][2]);
		if (dq_par_s[VQ_W] || dq_opp_s[VQ_W]) begin
			for (int e = 0; e < 9; e++) ent[e] = '0;
			ent[0] = dq_par_s[VQ_W] ? ONE_W : -ONE_W;
			ent[4] = ent[0];
			ent[8] = ent[0];
		end else begin
			ent[0] = qs[0] + cw;
			ent[1] = qs[3] - v2w;
			ent[2] = qs[4] + v1w;
			ent[3] = qs[3] + v2w;
			ent[4] = qs[1] + cw;
			ent[5] = qs[5] - v0w;
			ent[6] = qs[4] - v1w;
			ent[7] = qs[5] + v0w;
			ent[8] = qs[2] + cw;
		end
	end

	logic               done_q;
	logic signed [15:0] res_q [9];
	logic [1:0]         status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= dq_vld_s[VQ_W];
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < 9; e++) res_q[e] <= to_out(ent[e]);
		if (dq_par_s[VQ_W])      status_q <= ST_PARALLEL;
		else if (dq_opp_s[VQ_W]) status_q <= ST_OPPOSITE;
		else                     status_q <= ST_GENERAL;
	end

	assign done   = done_q;
	assign r00    = res_q[0];
	assign r01    = res_q[1];
	assign r02    = res_q[2];
	assign r10    = res_q[3];
	assign r11    = res_q[4];
	assign r12    = res_q[5];
	assign r20    = res_q[6];
	assign r21    = res_q[7];
	assign r22    = res_q[8];
	assign status = status_q;

	// degenerate result transfers and the shape of their matrices
	logic par_out, opp_out, par_shape, opp_shape;
	assign par_out   = done && status == ST_PARALLEL;
	assign opp_out   = done && status == ST_OPPOSITE;
	assign par_shape = r01 == 16'sd0 && r10 == 16'sd0 && r22 >= 16'sd0;
	assign opp_shape = r12 == 16'sd0 && r21 == 16'sd0 && r00 < 16'sd0;

	// both normalizers must deliver in the same cycle
	`RTAV_ASSERT_EQUAL(a_unit_lockstep, a_valid, b_valid, "unit vector pipelines out of step")
	// identity case has zero r01 and r10 and a non-negative r22
	`RTAV_ASSERT_IMPLY(a_parallel_offdiag, par_out, par_shape, "parallel result not identity")
	// negated identity case has zero r12 and r21 and a negative r00
	`RTAV_ASSERT_IMPLY(a_opposite_diag, opp_out, opp_shape, "opposite not negated identity")
endmodule

// ===== tb/sv/rotation_checker.sv =====
`timescale 1ns / 1ps
module rotation_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] src_x,
	input  logic signed [15:0] src_y,
	input  logic signed [15:0] src_z,
	input  logic signed [15:0] dst_x,
	input  logic signed [15:0] dst_y,
	input  logic signed [15:0] dst_z,
	input  logic               done,
	input  logic signed [15:0] r00,
	input  logic signed [15:0] r01,
	input  logic signed [15:0] r02,
	input  logic signed [15:0] r10,
	input  logic signed [15:0] r11,
	input  logic signed [15:0] r12,
	input  logic signed [15:0] r20,
	input  logic signed [15:0] r21,
	input  logic signed [15:0] r22,
	input  logic [1:0]         status,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 degenerate
);
	import rtav_pkg::*;

	typedef struct packed {
		logic [8:0][15:0] ent;
		logic [1:0]       st;
	} rotation_t;

	localparam longint ONE = 64'sd1 <<< 30;
	localparam longint EPS = 64'sd128;

	rotation_t matrix_q[$];

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector in q30, a zero vector stays zero
	function automatic void normalize(input logic [2:0][15:0] raw, output longint u [3]);
		logic            ng [3];
		longint unsigned mg [3];
		longint unsigned m, ssq, nrm, q;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			ng[i] = raw[i][15];
			mg[i] = ng[i] ? (64'd65536 - 64'(raw[i])) : 64'(raw[i]);
			if (mg[i] > m)
				m = mg[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++)
				u[i] = 0;
			return;
		end
		while (m < (64'd1 << 14)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++)
				mg[i] = mg[i] << 1;
		end
		while (m > (64'd1 << 15)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++)
				mg[i] = mg[i] >> 1;
		end
		ssq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
		nrm = isqrt(ssq << 32);
		for (int i = 0; i < 3; i++) begin
			q = (mg[i] << 46) / nrm;
			u[i] = ng[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic logic [15:0] to_q14(longint x);
		longint y;
		y = (x + (64'sd1 <<< 15)) >>> 16;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[15:0];
	endfunction

	function automatic rotation_t align_rotation(logic [2:0][15:0] s, logic [2:0][15:0] d);
		longint    a [3], b [3], v [3], r [9];
		longint    c, den;
		rotation_t res;
		normalize(s, a);
		normalize(d, b);
		c = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 30;
		if (c > ONE - EPS) begin
			res.st = ST_PARALLEL;
			for (int i = 0; i < 9; i++)
				r[i] = (i % 4 == 0) ? ONE : 0;
		end else if (c < -ONE + EPS) begin
			res.st = ST_OPPOSITE;
			for (int i = 0; i < 9; i++)
				r[i] = (i % 4 == 0) ? -ONE : 0;
		end else begin
			res.st = ST_GENERAL;
			v[0] = (a[1] * b[2] - a[2] * b[1]) >>> 30;
			v[1] = (a[2] * b[0] - a[0] * b[2]) >>> 30;
			v[2] = (a[0] * b[1] - a[1] * b[0]) >>> 30;
			den = ONE + c;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					r[i * 3 + j] = (v[i] * v[j]) / den + (i == j ? c : 0);
			r[1] -= v[2];
			r[2] += v[1];
			r[3] += v[2];
			r[5] -= v[0];
			r[6] -= v[1];
			r[7] += v[0];
		end
		for (int i = 0; i < 9; i++)
			res.ent[i] = to_q14(r[i]);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rotation_t        want;
		logic [8:0][15:0] got;
		int               bad;
		if (!arst_n) begin
			errors     <= 0;
			pending    <= 0;
			checked    <= 0;
			degenerate <= 0;
			matrix_q.delete();
		end else begin
			bad = 0;
			if (start && !busy)
				matrix_q.push_back(align_rotation({src_z, src_y, src_x}, {dst_z, dst_y, dst_x}));
			if (done) begin
				got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
				if (matrix_q.size() == 0) begin
					$error("unexpected result transfer");
					bad++;
				end else begin
					want = matrix_q.pop_front();
					checked <= checked + 1;
					if (want.st != ST_GENERAL)
						degenerate <= degenerate + 1;
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.ent[i]) begin
							$error("r%0d%0d expected %0d got %0d", i / 3, i % 3,
								$signed(want.ent[i]), $signed(got[i]));
							bad++;
						end
					if (status !== want.st) begin
						$error("status expected %0d got %0d", want.st, status);
						bad++;
					end
				end
			end
			errors  <= errors + bad;
			pending <= matrix_q.size();
		end
	end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
	logic               done;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic [1:0]         status;
	int                 errors, pending, checked, degenerate;
	int                 idle_pct;
	int                 sent;

	rotation_to_align_vectors_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.src_x(src_x), .src_y(src_y), .src_z(src_z),
		.dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
		.done(done),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22), .status(status)
	);

	// checker predicts every accepted transfer and compares on done
	rotation_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.src_x(src_x), .src_y(src_y), .src_z(src_z),
		.dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
		.done(done),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22), .status(status),
		.errors(errors), .pending(pending), .checked(checked), .degenerate(degenerate)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// clamp to the 16-bit range, used when building near-parallel and near-opposite pairs
	function automatic logic signed [15:0] clip(int x);
		if (x > 32767)
			return 16'sh7fff;
		if (x < -32768)
			return -16'sh8000;
		return x[15:0];
	endfunction

	// one vector pair transfer, with random idle cycles ahead of it
	task automatic send_pair(logic signed [15:0] sx, sy, sz, dx, dy, dz);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) begin
			start <= 1'b0;
			@(posedge clk);
			gap++;
		end
		start <= 1'b1;
		src_x <= sx;
		src_y <= sy;
		src_z <= sz;
		dst_x <= dx;
		dst_y <= dy;
		dst_z <= dz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// random component, sometimes tiny, sometimes an extreme
	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(9))
			0: return 16'($urandom_range(7)) - 16'sd3;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3: return 16'sd0;
			4: return 16'($urandom_range(511)) - 16'sd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pair();
		logic signed [15:0] s [3];
		logic signed [15:0] d [3];
		int                 sgn, nz, kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++)
			s[i] = rand_comp();
		sgn = (kind < 3) ? 1 : -1;
		nz = 1 << $urandom_range(8);
		for (int i = 0; i < 3; i++) begin
			if (kind < 6)
				// near parallel or near opposite: scaled copy plus small noise
				d[i] = clip(sgn * int'(s[i]) + int'($urandom_range(2 * nz)) - nz);
			else
				d[i] = rand_comp();
		end
		send_pair(s[0], s[1], s[2], d[0], d[1], d[2]);
	endtask

	initial begin
		int wait_cycles;
		arst_n   = 1'b0;
		start    = 1'b0;
		src_x    = '0;
		src_y    = '0;
		src_z    = '0;
		dst_x    = '0;
		dst_y    = '0;
		dst_z    = '0;
		idle_pct = 0;
		sent     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vectors, parallel, opposite, extremes, orthogonal
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 100, -5, 7);
		send_pair(3, 4, 5, 0, 0, 0);
		send_pair(1, 0, 0, 1, 0, 0);
		send_pair(1, 0, 0, 32767, 0, 0);
		send_pair(1, 0, 0, -1, 0, 0);
		send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(1, 0, 0, 0, 1, 0);
		send_pair(0, 1, 0, 0, 0, 1);
		send_pair(0, 0, 1, 1, 0, 0);
		send_pair(-32768, 0, 0, 0, 0, -32768);
		send_pair(32767, 1, 0, -32767, 0, 0);
		send_pair(32767, 0, 0, -32767, 2, 0);
		send_pair(32767, 0, 0, -32767, 200, 0);
		send_pair(32767, 0, 0, 32767, 3, 0);
		send_pair(32767, 0, 0, 32767, 300, -300);
		send_pair(1, 2, 3, -3, -2, -1);
		send_pair(-1, -1, -1, 16'sh5555, 16'sh2aaa, 16'sh0f0f);

		// random part in four idle phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 84;
				2: idle_pct = 0;
				default: idle_pct = 37;
			endcase
			repeat (490)
				random_pair();
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (150) @(posedge clk);

		$display("transfers sent %0d, results checked %0d, degenerate cases %0d",
			sent, checked, degenerate);
		if (errors == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// overall time limit
	initial begin
		#400000;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule
